// File: rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg: shared definitions for the masked byte pattern scanner
// Register indexes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // parameter defaults
    localparam int PATTERN_MAX_DEF  = 16;
    localparam int ADDRESS_BITS_DEF = 48;

    // fixed field widths
    localparam int BYTE_W    = 8;
    localparam int BASE_W    = 48;
    localparam int COUNT_W   = 16;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;
    localparam int S_DATA_W  = 56;   // data_byte + region_base, whole bytes
    localparam int S_USER_W  = 2;
    localparam int M_DATA_W  = 48;

    // bytes seen in a region saturate here
    localparam logic [LEN_W-1:0]   SEEN_MAX  = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_CARE_MASK    = 3'd2,
        REG_PATTERN_LEN  = 3'd3,
        REG_MATCH_INDEX  = 3'd4,
        REG_ADDR_OFFSET  = 3'd5
    } t_cfg_reg;

endpackage

// File: rtl/masked_byte_pattern_scanner.sv
// A transaction passes the input register and then the result register.
// Throughput: one byte per cycle while no result waits; the window compare, the
// occurrence count and the address add all settle in the single processing stage.
// Reset: synchronous, active low; clears control state, the byte window and
// restores the register defaults (care mask all ones, pattern length one).
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Streams memory bytes past a masked pattern of up to sixteen bytes, counts
// overlapping matches per region and reports the chosen occurrence's address
// or a single not-found result at the end of the scan.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner #(
    parameter int PATTERN_MAX  = mbps_pkg::PATTERN_MAX_DEF,
    parameter int ADDRESS_BITS = mbps_pkg::ADDRESS_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbps_pkg::CFG_DAT_W-1:0]   i_cfg_wdata,
    // byte stream in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mbps_pkg::S_DATA_W-1:0]    s_axis_tdata,  // data_byte, region_base
    input  logic [mbps_pkg::S_USER_W-1:0]    s_axis_tuser,  // new_scan, new_region
    input  logic                             s_axis_tlast,  // scan_end
    // result out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mbps_pkg::M_DATA_W-1:0]    m_axis_tdata,  // match_address
    output logic                             m_axis_tuser   // found
);
    import mbps_pkg::*;

    localparam int WIN_D = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int SUM_W = (ADDRESS_BITS < BASE_W) ? ADDRESS_BITS : BASE_W;

    // configuration registers
    logic [63:0]         r_pattern_low;
    logic [63:0]         r_pattern_high;
    logic [15:0]         r_care_mask;
    logic [LEN_W-1:0]    r_pattern_len;
    logic [COUNT_W-1:0]  r_match_index;
    logic signed [31:0]  r_addr_offset;

    // derived, end-aligned pattern
    logic [BYTE_W-1:0]   r_apat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_acare;
    logic [3:0]          r_nm1;
    logic [SUM_W-1:0]    r_adj;
    logic [BYTE_W-1:0]   n_apat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] n_acare;
    logic [3:0]          n_nm1;

    // input register
    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                r_in_new_scan;
    logic                r_in_new_region;
    logic [BASE_W-1:0]   r_in_base;
    logic                r_in_scan_end;

    // scan state
    logic [BYTE_W-1:0]   r_win [WIN_D];
    logic [LEN_W-1:0]    r_seen;
    logic [SUM_W-1:0]    r_abs;      // region base plus position of the next byte
    logic [COUNT_W-1:0]  r_count;
    logic                r_done;

    // result register
    logic                r_out_valid;
    logic                r_out_found;
    logic [M_DATA_W-1:0] r_out_addr;

    // processing stage signals
    logic                fire;
    logic                done_eff;
    logic [LEN_W-1:0]    seen_eff;
    logic [COUNT_W-1:0]  count_eff;
    logic [SUM_W-1:0]    abs_eff;
    logic [BYTE_W-1:0]   cmp_byte [PATTERN_MAX];
    logic                match;
    logic                hit;
    logic [SUM_W-1:0]    sum_addr;

    logic [BYTE_W-1:0]   n_win [WIN_D];
    logic [LEN_W-1:0]    n_seen;
    logic [SUM_W-1:0]    n_abs;
    logic [COUNT_W-1:0]  n_count;
    logic                n_done;
    logic                n_out_valid;
    logic                n_out_found;
    logic [M_DATA_W-1:0] n_out_addr;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low  <= '0;
            r_pattern_high <= '0;
            r_care_mask    <= 16'hFFFF;
            r_pattern_len  <= 5'd1;
            r_match_index  <= '0;
            r_addr_offset  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PATTERN_LOW:  r_pattern_low  <= i_cfg_wdata;
                REG_PATTERN_HIGH: r_pattern_high <= i_cfg_wdata;
                REG_CARE_MASK:    r_care_mask    <= i_cfg_wdata[15:0];
                REG_PATTERN_LEN:  r_pattern_len  <= i_cfg_wdata[LEN_W-1:0];
                REG_MATCH_INDEX:  r_match_index  <= i_cfg_wdata[COUNT_W-1:0];
                REG_ADDR_OFFSET:  r_addr_offset  <= signed'(i_cfg_wdata[31:0]);
                default: ;
            endcase
        end
    end

    // clamp the length and align the pattern so its last byte meets the newest
    always_comb begin
        logic [LEN_W-1:0] len;
        logic [3:0]       idx;
        logic [127:0]     pat;
        len = r_pattern_len;
        if (len == '0)
            len = 5'd1;
        if (len > LEN_W'(PATTERN_MAX))
            len = LEN_W'(PATTERN_MAX);
        n_nm1 = 4'(len - 5'd1);
        pat   = {r_pattern_high, r_pattern_low};
        for (int j = 0; j < PATTERN_MAX; j++) begin
            idx        = n_nm1 - 4'(j);
            n_apat[j]  = pat[idx*8 +: 8];
            n_acare[j] = (4'(j) <= n_nm1) && r_care_mask[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        r_apat  <= n_apat;
        r_acare <= n_acare;
        r_nm1   <= n_nm1;
        r_adj   <= SUM_W'(r_addr_offset) - SUM_W'(n_nm1);
    end

    // handshake
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte       <= s_axis_tdata[BYTE_W-1:0];
            r_in_base       <= s_axis_tdata[BYTE_W +: BASE_W];
            r_in_new_scan   <= s_axis_tuser[0];
            r_in_new_region <= s_axis_tuser[1];
            r_in_scan_end   <= s_axis_tlast;
        end
    end

    // region restart and masked compare against the window
    always_comb begin
        logic all_eq;
        done_eff  = r_in_new_scan ? 1'b0 : r_done;
        seen_eff  = r_in_new_region ? '0 : r_seen;
        count_eff = r_in_new_region ? '0 : r_count;
        abs_eff   = r_in_new_region ? SUM_W'(r_in_base) : r_abs;

        cmp_byte[0] = r_in_byte;
        for (int j = 1; j < PATTERN_MAX; j++)
            cmp_byte[j] = r_in_new_region ? '0 : r_win[j-1];

        all_eq = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++)
            if (r_acare[j] && (cmp_byte[j] != r_apat[j]))
                all_eq = 1'b0;

        match    = all_eq && (seen_eff >= LEN_W'(r_nm1));
        hit      = match && !done_eff && (count_eff == r_match_index);
        sum_addr = abs_eff + r_adj;
    end

    // next state and result
    always_comb begin
        n_win   = r_win;
        n_seen  = r_seen;
        n_abs   = r_abs;
        n_count = r_count;
        n_done  = r_done;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_found = r_out_found;
        n_out_addr  = r_out_addr;

        if (fire) begin
            n_out_valid = 1'b0;
            n_done      = done_eff;
            n_count     = count_eff;

            // occurrence handling
            if (hit) begin
                n_done      = 1'b1;
                n_out_valid = 1'b1;
                n_out_found = 1'b1;
                n_out_addr  = M_DATA_W'(sum_addr);
            end else if (match && !done_eff && (count_eff != COUNT_MAX)) begin
                n_count = count_eff + COUNT_W'(1);
            end

            // window shift and position advance
            for (int k = WIN_D - 1; k > 0; k--)
                n_win[k] = r_in_new_region ? '0 : r_win[k-1];
            n_win[0] = r_in_byte;
            n_seen   = (seen_eff < SEEN_MAX) ? seen_eff + LEN_W'(1) : seen_eff;
            n_abs    = abs_eff + SUM_W'(1);

            // scan end with nothing reported
            if (r_in_scan_end && !n_done) begin
                n_done      = 1'b1;
                n_out_valid = 1'b1;
                n_out_found = 1'b0;
                n_out_addr  = '0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_D; k++)
                r_win[k] <= '0;
            r_seen      <= '0;
            r_abs       <= '0;
            r_count     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_win       <= n_win;
            r_seen      <= n_seen;
            r_abs       <= n_abs;
            r_count     <= n_count;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_found <= n_out_found;
        r_out_addr  <= n_out_addr;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_found;

endmodule
